// ----- rtl/scsc_pkg.sv -----
// shared types, constants and helpers for the servo command slew controller
// no dependencies
package scsc_pkg;

  localparam int POS_W       = 10;
  localparam int TEMP_W      = 8;
  localparam int CFG_DATA_W  = 10;
  localparam int CFG_INDEX_W = 2;
  localparam int PULSE_V_W   = 12;
  localparam int PULSE_H_W   = 13;
  localparam int IR_DUTY_W   = 14;

  localparam logic [7:0] HDR_SERVO = 8'hAA;
  localparam logic [7:0] HDR_TEMP  = 8'hAB;
  localparam logic [7:0] HDR_IR    = 8'hAD;

  localparam logic [POS_W-1:0]     STEP_SIZE_RESET    = 10'd10;
  localparam logic [POS_W-1:0]     POS_LIMIT_RESET    = 10'd1000;
  localparam logic [TEMP_W-1:0]    FAN_ON_TEMP_RESET  = 8'd53;
  localparam logic [TEMP_W-1:0]    FAN_OFF_TEMP_RESET = 8'd48;
  localparam logic [IR_DUTY_W-1:0] IR_DUTY_FULL       = 14'd10000;
  localparam logic [3:0]           IR_LEVEL_MAX       = 4'd10;

  localparam logic [PULSE_V_W-1:0] PULSE_V_BASE = 12'd2020;
  localparam logic [PULSE_H_W-1:0] PULSE_H_BASE = 13'd1700;

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STEP_SIZE      = 2'd0,
    REG_POSITION_LIMIT = 2'd1,
    REG_FAN_ON_TEMP    = 2'd2,
    REG_FAN_OFF_TEMP   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [PULSE_V_W-1:0] pulse_vertical;
    logic [PULSE_H_W-1:0] pulse_horizontal;
    logic                 fan_on;
    logic [IR_DUTY_W-1:0] ir_duty;
    logic                 targets_loaded;
  } result_t;

  // 2020 + 2 * pos
  function automatic logic [PULSE_V_W-1:0] pulse_vertical_of(input pos_t pos);
    return PULSE_V_BASE + {1'b0, pos, 1'b0};
  endfunction

  // 1700 + floor(2.5 * pos) = 1700 + 2 * pos + pos / 2
  function automatic logic [PULSE_H_W-1:0] pulse_horizontal_of(input pos_t pos);
    return PULSE_H_BASE + {2'b00, pos, 1'b0} + {4'b0000, pos[POS_W-1:1]};
  endfunction

  // 10000 - 1000 * level
  function automatic logic [IR_DUTY_W-1:0] ir_duty_of(input logic [3:0] level);
    logic [IR_DUTY_W-1:0] drop;
    drop = IR_DUTY_W'(level) * IR_DUTY_W'(1000);
    return IR_DUTY_FULL - drop;
  endfunction

endpackage

// ----- rtl/scsc_item_if.sv -----
// input channel: one command frame or timer tick per transfer
// depends on nothing
interface scsc_item_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] header;
  logic [7:0] byte_one;
  logic [7:0] byte_two;
  logic [7:0] byte_three;
  logic [7:0] byte_four;
  logic [7:0] check_byte;

  modport source (output valid, cmd, header, byte_one, byte_two, byte_three, byte_four,
                  check_byte, input ready);
  modport sink (input valid, cmd, header, byte_one, byte_two, byte_three, byte_four,
                check_byte, output ready);
endinterface

// ----- rtl/scsc_result_if.sv -----
// output channel: pulse widths and drive state, one transfer per item
// depends on nothing
interface scsc_result_if;
  logic        valid;
  logic        ready;
  logic [11:0] pulse_vertical;
  logic [12:0] pulse_horizontal;
  logic        fan_on;
  logic [13:0] ir_duty;
  logic        targets_loaded;

  modport source (output valid, pulse_vertical, pulse_horizontal, fan_on, ir_duty,
                  targets_loaded, input ready);
  modport sink (input valid, pulse_vertical, pulse_horizontal, fan_on, ir_duty,
                targets_loaded, output ready);
endinterface

// ----- rtl/scsc_slew.sv -----
// one axis of the slew limiter: step toward target, clamp, snap within two steps
// depends on scsc_pkg
module scsc_slew
  import scsc_pkg::*;
(
  input  pos_t       position,
  input  pos_t       target,
  input  logic       up,
  input  pos_t       step_size,
  output pos_t       position_next
);

  logic [POS_W:0]   step_up;
  pos_t             stepped;
  pos_t             moved;
  pos_t             diff;
  logic [POS_W:0]   window;

  always_comb begin
    step_up = {1'b0, position} + {1'b0, step_size};
    if (up) begin
      stepped = step_up[POS_W] ? '1 : step_up[POS_W-1:0];
    end else begin
      stepped = (step_size > position) ? '0 : position - step_size;
    end
    moved = (position != target) ? stepped : position;
    diff = (moved >= target) ? moved - target : target - moved;
    window = {step_size, 1'b0};
    position_next = ({1'b0, diff} < window) ? target : moved;
  end

endmodule

// ----- rtl/servo_command_slew_controller_core.sv -----
// servo command slew controller, top level
// depends on scsc_pkg, scsc_item_if, scsc_result_if, scsc_slew
//
// throughput: one item per cycle while the skid entry is empty; the whole state update sits
//   combinationally between the input handshake and the result register, and a two-entry
//   output stage takes one more item, parked in the skid entry, while a result waits
// reset: synchronous, clears positions, targets and directions, fan on, ir duty 10000,
//   configuration registers to 10 / 1000 / 53 / 48
module servo_command_slew_controller_core
  import scsc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  scsc_item_if.sink              item,
  scsc_result_if.source          result
);

  // configuration registers
  pos_t              step_size;
  pos_t              position_limit;
  logic [TEMP_W-1:0] fan_on_temp;
  logic [TEMP_W-1:0] fan_off_temp;

  // controller state
  pos_t                 target_vertical;
  pos_t                 target_horizontal;
  pos_t                 position_vertical;
  pos_t                 position_horizontal;
  logic                 dir_vertical_up;
  logic                 dir_horizontal_up;
  logic                 fan_state;
  logic [IR_DUTY_W-1:0] ir_level_value;

  pos_t                 target_vertical_next;
  pos_t                 target_horizontal_next;
  pos_t                 position_vertical_next;
  pos_t                 position_horizontal_next;
  logic                 dir_vertical_up_next;
  logic                 dir_horizontal_up_next;
  logic                 fan_state_next;
  logic [IR_DUTY_W-1:0] ir_level_value_next;
  logic                 loaded;

  // output stage: result register plus skid entry
  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;
  result_t result_new;

  logic    accept;
  logic    out_free;

  // frame decode
  logic [7:0]  checksum;
  logic [15:0] raw_vertical;
  logic [15:0] raw_horizontal;
  pos_t        clip_vertical;
  pos_t        clip_horizontal;
  logic [3:0]  ir_high;
  logic [3:0]  ir_low;
  pos_t        slew_vertical;
  pos_t        slew_horizontal;

  // ready as long as the skid entry is empty
  assign item.ready = !skid_valid;
  assign accept     = item.valid && item.ready;
  assign out_free   = !out_valid || result.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size      <= STEP_SIZE_RESET;
      position_limit <= POS_LIMIT_RESET;
      fan_on_temp    <= FAN_ON_TEMP_RESET;
      fan_off_temp   <= FAN_OFF_TEMP_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_STEP_SIZE:      step_size      <= cfg_data;
        REG_POSITION_LIMIT: position_limit <= cfg_data;
        REG_FAN_ON_TEMP:    fan_on_temp    <= cfg_data[TEMP_W-1:0];
        REG_FAN_OFF_TEMP:   fan_off_temp   <= cfg_data[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // one slew unit per axis, used on ticks
  scsc_slew u_slew_vertical (
    .position      (position_vertical),
    .target        (target_vertical),
    .up            (dir_vertical_up),
    .step_size     (step_size),
    .position_next (slew_vertical)
  );

  scsc_slew u_slew_horizontal (
    .position      (position_horizontal),
    .target        (target_horizontal),
    .up            (dir_horizontal_up),
    .step_size     (step_size),
    .position_next (slew_horizontal)
  );

  // frame fields
  always_comb begin
    checksum       = item.byte_one + item.byte_two + item.byte_three + item.byte_four;
    raw_vertical   = {item.byte_one, item.byte_two};
    raw_horizontal = {item.byte_three, item.byte_four};
    // saturate received targets to the limit register
    clip_vertical   = (raw_vertical >= {6'd0, position_limit}) ? position_limit
                                                                : raw_vertical[POS_W-1:0];
    clip_horizontal = (raw_horizontal >= {6'd0, position_limit}) ? position_limit
                                                                  : raw_horizontal[POS_W-1:0];
    // ir code: high nibble must equal the complement of the low nibble
    ir_high = item.byte_one[7:4];
    ir_low  = ~item.byte_one[3:0];
  end

  // state update for one item
  always_comb begin
    target_vertical_next     = target_vertical;
    target_horizontal_next   = target_horizontal;
    position_vertical_next   = position_vertical;
    position_horizontal_next = position_horizontal;
    dir_vertical_up_next     = dir_vertical_up;
    dir_horizontal_up_next   = dir_horizontal_up;
    fan_state_next           = fan_state;
    ir_level_value_next      = ir_level_value;
    loaded                   = 1'b0;

    if (item.cmd) begin
      // timer tick: both axes move
      position_vertical_next   = slew_vertical;
      position_horizontal_next = slew_horizontal;
    end else begin
      case (item.header)
        HDR_SERVO: begin
          if (checksum == item.check_byte) begin
            target_vertical_next   = clip_vertical;
            target_horizontal_next = clip_horizontal;
            loaded                 = 1'b1;
          end
          // direction is recomputed from the (possibly unchanged) target even on a bad checksum
          dir_vertical_up_next   = target_vertical_next > position_vertical;
          dir_horizontal_up_next = target_horizontal_next > position_horizontal;
        end
        HDR_TEMP: begin
          // hysteresis, turn-on test wins when thresholds overlap
          if (item.byte_one >= fan_on_temp) begin
            fan_state_next = 1'b1;
          end else if (item.byte_one <= fan_off_temp) begin
            fan_state_next = 1'b0;
          end
        end
        HDR_IR: begin
          if (ir_high == ir_low && ir_high <= IR_LEVEL_MAX) begin
            ir_level_value_next = ir_duty_of(ir_high);
          end
        end
        default: ;
      endcase
    end

    // result reflects the state after the update
    result_new.pulse_vertical   = pulse_vertical_of(position_vertical_next);
    result_new.pulse_horizontal = pulse_horizontal_of(position_horizontal_next);
    result_new.fan_on           = fan_state_next;
    result_new.ir_duty          = ir_level_value_next;
    result_new.targets_loaded   = loaded;
  end

  // state registers, updated on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      target_vertical     <= '0;
      target_horizontal   <= '0;
      position_vertical   <= '0;
      position_horizontal <= '0;
      dir_vertical_up     <= 1'b0;
      dir_horizontal_up   <= 1'b0;
      fan_state           <= 1'b1;
      ir_level_value      <= IR_DUTY_FULL;
    end else if (accept) begin
      target_vertical     <= target_vertical_next;
      target_horizontal   <= target_horizontal_next;
      position_vertical   <= position_vertical_next;
      position_horizontal <= position_horizontal_next;
      dir_vertical_up     <= dir_vertical_up_next;
      dir_horizontal_up   <= dir_horizontal_up_next;
      fan_state           <= fan_state_next;
      ir_level_value      <= ir_level_value_next;
    end
  end

  // output stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        // drain the skid entry; no transfer can be taken this cycle
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      // result register stalled, park the new result
      skid_valid <= 1'b1;
    end
  end

  // output stage payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : result_new;
    end
    if (!out_free && accept) begin
      skid_data <= result_new;
    end
  end

  assign result.valid            = out_valid;
  assign result.pulse_vertical   = out_data.pulse_vertical;
  assign result.pulse_horizontal = out_data.pulse_horizontal;
  assign result.fan_on           = out_data.fan_on;
  assign result.ir_duty          = out_data.ir_duty;
  assign result.targets_loaded   = out_data.targets_loaded;

endmodule
